// ----- rtl/cle_pkg.sv -----
// Shared types and constants for the cooked line editor.
// Used by cle_ctrl, cle_datapath and cooked_line_editor_core; no dependencies.
package cle_pkg;

    localparam logic [7:0] KEY_EOT    = 8'h04;
    localparam logic [7:0] KEY_BS     = 8'h08;
    localparam logic [7:0] KEY_NL     = 8'h0A;
    localparam logic [7:0] KEY_KILL   = 8'h15;
    localparam logic [7:0] KEY_WERASE = 8'h17;
    localparam logic [7:0] KEY_SPACE  = 8'h20;
    localparam logic [7:0] KEY_TILDE  = 8'h7E;

    localparam int unsigned CELLS_W   = 10;
    localparam int unsigned LEN_W     = 7;

    typedef enum logic [2:0] {
        KIND_NONE   = 3'd0,
        KIND_ECHO   = 3'd1,
        KIND_ERASE  = 3'd2,
        KIND_DATA   = 3'd3,
        KIND_EOF    = 3'd4,
        KIND_NOLINE = 3'd5,
        KIND_BUSY   = 3'd6
    } t_kind;

    typedef enum logic [2:0] {
        KC_OTHER,
        KC_NL,
        KC_EOT,
        KC_BS,
        KC_KILL,
        KC_WERASE,
        KC_PRINT
    } t_key_class;

    typedef enum logic [1:0] {
        BSRC_ZERO,
        BSRC_KEY,
        BSRC_RAM
    } t_byte_src;

    typedef enum logic [1:0] {
        CSRC_ZERO,
        CSRC_ONE,
        CSRC_CNT,
        CSRC_FILL
    } t_cells_src;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       cap;
        logic       emit;
        t_kind      kind;
        t_byte_src  byte_src;
        t_cells_src cells_src;
        logic       last;
        logic       push;
        logic       fill_dec;
        logic       fill_clr;
        logic       set_complete;
        logic       set_eof;
        logic       clr_eof;
        logic       ws_read;
        logic       rd_read;
        logic       clear_line;
        logic       cnt_clr;
        logic       cnt_inc;
        logic       rem_load;
        logic       rem_dec;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       is_read;
        t_key_class key_class;
        logic       raw;
        logic       busy;
        logic       eof;
        logic       complete;
        logic       fill_zero;
        logic       fill_full;
        logic       fill_lt_max;
        logic       len_zero;
        logic       avail_zero;
        logic       rem_one;
        logic       rpos_ge_fill;
        logic       rd_space;
        logic       cnt_zero;
        logic       out_free;
    } t_dp_sts;

endpackage

// ----- rtl/cooked_line_editor_core.sv -----
// Top level of the cooked line editor: controller plus datapath.
// Depends on cle_pkg, cle_ctrl, cle_datapath and cle_ram.
//
// The block is a terminal line discipline. Items arrive on the slave stream: tuser
// selects a key byte (0) or a read request (1), tdata carries the key byte and the
// most bytes the read may take. Results leave on the master stream: tuser is the
// result kind, tdata the echoed or delivered byte and the cells to rub out, tlast
// marks the final result of an item. Raw mode is written through i_cfg_we/i_cfg_wdata
// by the user only while the block is idle; the block itself does not enforce this.
//
// One item is worked on at a time; s_axis_tready is high only when idle. A key
// item is captured in S_IDLE and, except for word erase, its result is loaded in
// S_DECODE once the output register is free; the next item is taken back in S_IDLE.
// Word erase reads the store one cell at a time, through S_WS_ISSUE and S_WS_CHECK,
// and loads its result in S_WS_DONE. A read loads each byte by a store read in
// S_RD_ISSUE, then an output load in S_RD_DATA.
//
// The output register decouples the sides: a new item is accepted while the last
// result waits for m_axis_tready, and work stalls only while a new result finds it
// full. Reset empties the line, clears pending states and selects cooked mode.
module cooked_line_editor_core #(
    parameter int unsigned LINE_MAX = 1024,
    parameter int unsigned READ_MAX = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,     // raw_mode
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,    // key_byte[7:0], max_len[14:8], zero pad
    input  logic        s_axis_tuser,    // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,    // byte_value[7:0], erase_cells[17:8], zero pad
    output logic [2:0]  m_axis_tuser,    // kind
    output logic        m_axis_tlast     // last
);
    import cle_pkg::*;

    t_dp_cmd            ctl;
    t_dp_sts            sts;
    t_kind              out_kind;
    logic [7:0]         out_byte;
    logic [CELLS_W-1:0] out_cells;

    cle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (ctl)
    );

    cle_datapath #(
        .LINE_MAX (LINE_MAX),
        .READ_MAX (READ_MAX)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_cmd         (s_axis_tuser),
        .i_key_byte    (s_axis_tdata[7:0]),
        .i_max_len     (s_axis_tdata[14:8]),
        .i_ctl         (ctl),
        .o_sts         (sts),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_kind        (out_kind),
        .o_byte_value  (out_byte),
        .o_erase_cells (out_cells),
        .o_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {6'b000000, out_cells, out_byte};
    assign m_axis_tuser = out_kind;

    // A new result is loaded only when the output register is free.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.emit |-> sts.out_free)
        else $error("result loaded over a pending result");

    // Keys are appended only to an open line with room left.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.push |-> (!sts.busy && sts.fill_lt_max))
        else $error("line store written while busy or full");

    // An accepted item blocks the input until its work is done.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second item accepted while one is in progress");

    // Data reads never run past the end of the line.
    a_read_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.rd_read |-> (!sts.rpos_ge_fill && sts.complete))
        else $error("line read beyond its fill count");

endmodule

// ----- rtl/cle_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cle_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/cle_ctrl.sv -----
// Controller state machine of the cooked line editor.
// Depends on cle_pkg; drives the datapath by t_dp_cmd and reads t_dp_sts.
module cle_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  cle_pkg::t_dp_sts i_sts,
    output cle_pkg::t_dp_cmd o_cmd
);
    import cle_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_WS_ISSUE,
        S_WS_CHECK,
        S_WS_DONE,
        S_RD_ISSUE,
        S_RD_DATA
    } t_state;

    t_state  r_state, n_state;
    logic    r_word, n_word;
    t_dp_cmd cmd;

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        n_word  = r_word;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.cap = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!i_sts.is_read && !i_sts.raw && !i_sts.busy &&
                    i_sts.key_class == KC_WERASE) begin
                    cmd.cnt_clr = 1'b1;
                    n_word      = 1'b0;
                    n_state     = S_WS_ISSUE;
                end else if (i_sts.is_read && !i_sts.len_zero && !i_sts.raw &&
                             !i_sts.eof && i_sts.complete && !i_sts.avail_zero) begin
                    cmd.rem_load = 1'b1;
                    n_state      = S_RD_ISSUE;
                end else if (i_sts.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.last = 1'b1;
                    n_state  = S_IDLE;
                    if (!i_sts.is_read) begin
                        if (i_sts.raw) begin
                            cmd.kind     = KIND_DATA;
                            cmd.byte_src = BSRC_KEY;
                        end else if (i_sts.busy) begin
                            cmd.kind = KIND_BUSY;
                        end else begin
                            unique case (i_sts.key_class)
                                KC_NL: begin
                                    cmd.push         = i_sts.fill_lt_max;
                                    cmd.set_complete = 1'b1;
                                    cmd.kind         = KIND_ECHO;
                                    cmd.byte_src     = BSRC_KEY;
                                end
                                KC_EOT: begin
                                    cmd.set_eof      = i_sts.fill_zero;
                                    cmd.set_complete = !i_sts.fill_zero;
                                    cmd.kind         = KIND_NONE;
                                end
                                KC_BS: begin
                                    cmd.fill_dec  = !i_sts.fill_zero;
                                    cmd.kind      = i_sts.fill_zero ? KIND_NONE : KIND_ERASE;
                                    cmd.cells_src = i_sts.fill_zero ? CSRC_ZERO : CSRC_ONE;
                                end
                                KC_KILL: begin
                                    cmd.fill_clr  = 1'b1;
                                    cmd.kind      = i_sts.fill_zero ? KIND_NONE : KIND_ERASE;
                                    cmd.cells_src = i_sts.fill_zero ? CSRC_ZERO : CSRC_FILL;
                                end
                                KC_PRINT: begin
                                    cmd.push     = !i_sts.fill_full;
                                    cmd.kind     = i_sts.fill_full ? KIND_NONE : KIND_ECHO;
                                    cmd.byte_src = i_sts.fill_full ? BSRC_ZERO : BSRC_KEY;
                                end
                                default: begin
                                    cmd.kind = KIND_NONE;
                                end
                            endcase
                        end
                    end else begin
                        if (i_sts.len_zero) begin
                            cmd.kind = KIND_NONE;
                        end else if (i_sts.raw) begin
                            cmd.kind = KIND_NOLINE;
                        end else if (i_sts.eof) begin
                            cmd.clr_eof = 1'b1;
                            cmd.kind    = KIND_EOF;
                        end else if (!i_sts.complete) begin
                            cmd.kind = KIND_NOLINE;
                        end else begin
                            // A completed line with nothing left to hand out.
                            cmd.clear_line = 1'b1;
                            cmd.kind       = KIND_NONE;
                        end
                    end
                end
            end
            S_WS_ISSUE: begin
                if (i_sts.fill_zero) begin
                    n_state = S_WS_DONE;
                end else begin
                    cmd.ws_read = 1'b1;
                    n_state     = S_WS_CHECK;
                end
            end
            S_WS_CHECK: begin
                // First trailing spaces go, then the word before them.
                if (!r_word || !i_sts.rd_space) begin
                    cmd.fill_dec = 1'b1;
                    cmd.cnt_inc  = 1'b1;
                    if (!i_sts.rd_space) begin
                        n_word = 1'b1;
                    end
                    n_state = S_WS_ISSUE;
                end else begin
                    n_state = S_WS_DONE;
                end
            end
            S_WS_DONE: begin
                if (i_sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.last      = 1'b1;
                    cmd.kind      = i_sts.cnt_zero ? KIND_NONE : KIND_ERASE;
                    cmd.cells_src = i_sts.cnt_zero ? CSRC_ZERO : CSRC_CNT;
                    n_state       = S_IDLE;
                end
            end
            S_RD_ISSUE: begin
                cmd.rd_read = 1'b1;
                n_state     = S_RD_DATA;
            end
            S_RD_DATA: begin
                if (i_sts.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.kind     = KIND_DATA;
                    cmd.byte_src = BSRC_RAM;
                    cmd.last     = i_sts.rem_one;
                    cmd.rem_dec  = 1'b1;
                    if (i_sts.rem_one) begin
                        cmd.clear_line = i_sts.rpos_ge_fill;
                        n_state        = S_IDLE;
                    end else begin
                        n_state = S_RD_ISSUE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_word  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_word  <= n_word;
        end
    end

endmodule

// ----- rtl/cle_datapath.sv -----
// Datapath of the cooked line editor: line store, counters, flags and output register.
// Depends on cle_pkg and cle_ram; commanded by cle_ctrl.
module cle_datapath #(
    parameter int unsigned LINE_MAX = 1024,
    parameter int unsigned READ_MAX = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_wdata,
    input  logic                         i_cmd,
    input  logic [7:0]                   i_key_byte,
    input  logic [cle_pkg::LEN_W-1:0]    i_max_len,
    input  cle_pkg::t_dp_cmd             i_ctl,
    output cle_pkg::t_dp_sts             o_sts,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output cle_pkg::t_kind               o_kind,
    output logic [7:0]                   o_byte_value,
    output logic [cle_pkg::CELLS_W-1:0]  o_erase_cells,
    output logic                         o_last
);
    import cle_pkg::*;

    localparam int unsigned FILL_W = $clog2(LINE_MAX + 1);
    localparam int unsigned ADDR_W = $clog2(LINE_MAX);
    localparam int unsigned CMP_W  = (FILL_W > LEN_W) ? FILL_W : LEN_W;
    localparam int unsigned SAT_W  = (FILL_W > CELLS_W) ? FILL_W : CELLS_W;
    localparam logic [SAT_W-1:0] CELLS_MAX = SAT_W'((1 << CELLS_W) - 1);

    logic                r_raw;
    logic                r_is_read;
    logic [7:0]          r_key;
    logic [LEN_W-1:0]    r_len;
    logic [FILL_W-1:0]   r_fill;
    logic [FILL_W-1:0]   r_rpos;
    logic                r_complete;
    logic                r_eof;
    logic [FILL_W-1:0]   r_cnt;
    logic [LEN_W-1:0]    r_rem;
    logic                r_out_valid;
    t_kind               r_kind;
    logic [7:0]          r_byte;
    logic [CELLS_W-1:0]  r_cells;
    logic                r_last;

    logic [7:0]          ram_rdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [FILL_W-1:0]   fill_m1;
    logic [FILL_W-1:0]   avail;
    logic [LEN_W-1:0]    len_c;
    logic [CMP_W-1:0]    avail_ext;
    logic [CMP_W-1:0]    len_ext;
    logic [LEN_W-1:0]    rem_init;
    logic [SAT_W-1:0]    cells_raw;
    logic [CELLS_W-1:0]  cells_sat;
    logic [7:0]          byte_sel;
    logic                out_free;
    t_key_class          key_class;

    assign fill_m1   = r_fill - FILL_W'(1);
    assign ram_raddr = i_ctl.ws_read ? fill_m1[ADDR_W-1:0] : r_rpos[ADDR_W-1:0];

    cle_ram #(
        .WIDTH (8),
        .DEPTH (LINE_MAX)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_ctl.push),
        .i_waddr (r_fill[ADDR_W-1:0]),
        .i_wdata (r_key),
        .i_re    (i_ctl.ws_read || i_ctl.rd_read),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        unique case (r_key) inside
            KEY_NL:                key_class = KC_NL;
            KEY_EOT:               key_class = KC_EOT;
            KEY_BS:                key_class = KC_BS;
            KEY_KILL:              key_class = KC_KILL;
            KEY_WERASE:            key_class = KC_WERASE;
            [KEY_SPACE:KEY_TILDE]: key_class = KC_PRINT;
            default:               key_class = KC_OTHER;
        endcase
    end

    // Read length, clamped, and the bytes left in the line.
    assign len_c     = (r_len > LEN_W'(READ_MAX)) ? LEN_W'(READ_MAX) : r_len;
    assign avail     = r_fill - r_rpos;
    assign avail_ext = CMP_W'(avail);
    assign len_ext   = CMP_W'(len_c);
    assign rem_init  = (avail_ext < len_ext) ? LEN_W'(avail_ext) : len_c;

    always_comb begin
        case (i_ctl.cells_src)
            CSRC_ONE:  cells_raw = SAT_W'(1);
            CSRC_CNT:  cells_raw = SAT_W'(r_cnt);
            CSRC_FILL: cells_raw = SAT_W'(r_fill);
            default:   cells_raw = '0;
        endcase
        case (i_ctl.byte_src)
            BSRC_KEY: byte_sel = r_key;
            BSRC_RAM: byte_sel = ram_rdata;
            default:  byte_sel = 8'h00;
        endcase
    end

    assign cells_sat = (cells_raw > CELLS_MAX) ? CELLS_MAX[CELLS_W-1:0]
                                               : cells_raw[CELLS_W-1:0];
    assign out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        o_sts.is_read      = r_is_read;
        o_sts.key_class    = key_class;
        o_sts.raw          = r_raw;
        o_sts.busy         = r_complete || r_eof;
        o_sts.eof          = r_eof;
        o_sts.complete     = r_complete;
        o_sts.fill_zero    = (r_fill == '0);
        o_sts.fill_full    = (r_fill >= FILL_W'(LINE_MAX - 1));
        o_sts.fill_lt_max  = (r_fill < FILL_W'(LINE_MAX));
        o_sts.len_zero     = (r_len == '0);
        o_sts.avail_zero   = (r_rpos >= r_fill);
        o_sts.rem_one      = (r_rem == LEN_W'(1));
        o_sts.rpos_ge_fill = (r_rpos >= r_fill);
        o_sts.rd_space     = (ram_rdata == KEY_SPACE);
        o_sts.cnt_zero     = (r_cnt == '0);
        o_sts.out_free     = out_free;
    end

    // Control state: line bookkeeping, mode and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw       <= 1'b0;
            r_fill      <= '0;
            r_rpos      <= '0;
            r_complete  <= 1'b0;
            r_eof       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_raw <= i_cfg_wdata;
            end
            if (i_ctl.push) begin
                r_fill <= r_fill + FILL_W'(1);
            end else if (i_ctl.fill_dec) begin
                r_fill <= fill_m1;
            end else if (i_ctl.fill_clr || i_ctl.clear_line) begin
                r_fill <= '0;
            end
            if (i_ctl.set_complete || i_ctl.clear_line) begin
                r_rpos <= '0;
            end else if (i_ctl.rd_read) begin
                r_rpos <= r_rpos + FILL_W'(1);
            end
            if (i_ctl.set_complete) begin
                r_complete <= 1'b1;
            end else if (i_ctl.clear_line) begin
                r_complete <= 1'b0;
            end
            if (i_ctl.set_eof) begin
                r_eof <= 1'b1;
            end else if (i_ctl.clr_eof) begin
                r_eof <= 1'b0;
            end
            if (i_ctl.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_ctl.cap) begin
            r_is_read <= i_cmd;
            r_key     <= i_key_byte;
            r_len     <= i_max_len;
        end
        if (i_ctl.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_ctl.cnt_inc) begin
            r_cnt <= r_cnt + FILL_W'(1);
        end
        if (i_ctl.rem_load) begin
            r_rem <= rem_init;
        end else if (i_ctl.rem_dec) begin
            r_rem <= r_rem - LEN_W'(1);
        end
        if (i_ctl.emit) begin
            r_kind  <= i_ctl.kind;
            r_byte  <= byte_sel;
            r_cells <= cells_sat;
            r_last  <= i_ctl.last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_byte_value  = r_byte;
    assign o_erase_cells = r_cells;
    assign o_last        = r_last;

endmodule
